@@ rtl/core/fctc_pkg.sv @@
// fctc_pkg: shared types and constants of the floor and ceiling texel caster
// used by the channel interfaces and the top level; depends on nothing

package fctc_pkg;

    // default geometry handed to the top level parameters
    localparam int DEF_SCREEN_WIDTH    = 640;
    localparam int DEF_SCREEN_HEIGHT   = 480;
    localparam int DEF_TEX_WIDTH_LOG2  = 6;
    localparam int DEF_TEX_HEIGHT_LOG2 = 6;

    // fixed field widths
    localparam int PIX_X_W  = 10;
    localparam int PIX_Y_W  = 9;
    localparam int ADDR_W   = 12;
    localparam int TEXEL_W  = 32;
    localparam int ORIGIN_W = 48;
    localparam int VEC_W    = 16;
    localparam int HDIV_W   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int DIST_W   = 24;

    localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;

    // commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SHADE = 1'b1;

    // surfaces
    localparam logic SURF_FLOOR = 1'b0;
    localparam logic SURF_CEIL  = 1'b1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLOOR_ORIGIN = 3'd0,
        CFG_CEIL_ORIGIN  = 3'd1,
        CFG_VIEW_DIR_X   = 3'd2,
        CFG_VIEW_DIR_Y   = 3'd3,
        CFG_CAM_PLANE_X  = 3'd4,
        CFG_CAM_PLANE_Y  = 3'd5,
        CFG_HORIZON_DIV  = 3'd6
    } t_cfg_idx;

    // register reset values
    localparam logic [ORIGIN_W-1:0] RST_ORIGIN      = '0;
    localparam logic [VEC_W-1:0]    RST_VIEW_DIR_X  = 16'd16384;
    localparam logic [VEC_W-1:0]    RST_VIEW_DIR_Y  = 16'd0;
    localparam logic [VEC_W-1:0]    RST_CAM_PLANE_X = 16'd0;
    localparam logic [VEC_W-1:0]    RST_CAM_PLANE_Y = 16'd10813;
    localparam logic [HDIV_W-1:0]   RST_HORIZON_DIV = 5'd2;

    // item information that travels with every pipeline stage
    typedef struct packed {
        logic                valid;
        logic                command;
        logic                keep;
        logic                surface;
        logic [PIX_X_W-1:0]  pixel_x;
        logic [PIX_Y_W-1:0]  pixel_y;
        logic [ADDR_W-1:0]   texel_addr;
        logic [TEXEL_W-1:0]  texel_data;
    } t_info;

endpackage

@@ rtl/core/fctc_if.sv @@
// fctc channel interfaces: command input, pixel result output, register write
// depends on fctc_pkg for the field widths

interface fctc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [fctc_pkg::PIX_X_W-1:0]  pixel_x;
    logic [fctc_pkg::PIX_Y_W-1:0]  pixel_y;
    logic [fctc_pkg::ADDR_W-1:0]   texel_addr;
    logic [fctc_pkg::TEXEL_W-1:0]  texel_data;

    modport source (output valid, command, pixel_x, pixel_y, texel_addr, texel_data,
                    input ready);
    modport sink   (input valid, command, pixel_x, pixel_y, texel_addr, texel_data,
                    output ready);
endinterface

interface fctc_out_if;
    logic                          valid;
    logic                          ready;
    logic [fctc_pkg::PIX_X_W-1:0]  out_x;
    logic [fctc_pkg::PIX_Y_W-1:0]  out_y;
    logic [fctc_pkg::TEXEL_W-1:0]  color;
    logic                          surface;

    modport source (output valid, out_x, out_y, color, surface, input ready);
    modport sink   (input valid, out_x, out_y, color, surface, output ready);
endinterface

interface fctc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [fctc_pkg::CFG_IDX_W-1:0]  index;
    logic [fctc_pkg::ORIGIN_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/floor_ceiling_texel_caster.sv @@
// floor_ceiling_texel_caster: top level, pipelined floor and ceiling texel lookup
// depends on fctc_pkg and the interfaces in fctc_if
//
// Usage
//   i_in carries commands. A load command writes texel_data at texel_addr into the
//   texture memory; a shade command casts pixel (pixel_x, pixel_y) onto the floor or
//   ceiling and returns out_x, out_y, the texel color and the surface on o_out.
//   Shade commands in the horizon band, the bottom row or the last column give no
//   result. Loads and shades travel the same pipeline, so a shade sees exactly the
//   loads transferred before it.
//   i_cfg writes one register per transfer (always ready); write only while idle.
// Throughput and pipeline
//   One command per cycle while the receiver does not stall. A one-bit-per-stage
//   distance divider of HB + 16 stages, HB being the bit width of SCREEN_HEIGHT,
//   makes up most of the pipeline; the divide by the screen width is a four-stage
//   reciprocal multiply and the texture memory read is the final stage.
// Reset and stall
//   Reset clears all stage valid bits and loads the register defaults; the texture
//   memory is undefined until written. When the receiver stalls the whole pipeline
//   holds and i_in.ready falls; nothing is lost or repeated.

module floor_ceiling_texel_caster #(
    parameter int SCREEN_WIDTH    = fctc_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT   = fctc_pkg::DEF_SCREEN_HEIGHT,
    parameter int TEX_WIDTH_LOG2  = fctc_pkg::DEF_TEX_WIDTH_LOG2,
    parameter int TEX_HEIGHT_LOG2 = fctc_pkg::DEF_TEX_HEIGHT_LOG2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fctc_in_if.sink     i_in,
    fctc_out_if.source  o_out,
    fctc_cfg_if.sink    i_cfg
);
    import fctc_pkg::*;

    localparam int HB  = $clog2(SCREEN_HEIGHT + 1);
    localparam int WB  = $clog2(SCREEN_WIDTH + 1);
    localparam int DNW = HB + 16;
    localparam int DDW = 14;
    localparam int MW  = 42;
    localparam int CW  = 14;
    localparam logic [DNW-1:0] FLOOR_NUM = DNW'(SCREEN_HEIGHT * 32768);

    // reciprocal of the screen width, rounded up, exact for MW-bit dividends
    localparam int WS  = MW + WB;
    localparam int NLW = MW / 2;
    localparam int RLW = (MW + 2) / 2;
    localparam int PPW = NLW + RLW;
    localparam int PW  = 2 * MW + 2;
    localparam logic [63:0] RECIP = ((64'd1 << WS) + 64'(SCREEN_WIDTH) - 64'd1)
                                    / 64'(SCREEN_WIDTH);
    localparam logic [RLW-1:0] RECIP_HI = RECIP[MW+1:RLW];
    localparam logic [RLW-1:0] RECIP_LO = RECIP[RLW-1:0];

    // configuration registers
    logic [ORIGIN_W-1:0]      r_floor_org;
    logic [ORIGIN_W-1:0]      r_ceil_org;
    logic signed [VEC_W-1:0]  r_dir_x;
    logic signed [VEC_W-1:0]  r_dir_y;
    logic signed [VEC_W-1:0]  r_plane_x;
    logic signed [VEC_W-1:0]  r_plane_y;
    logic [HDIV_W-1:0]        r_hdiv;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor_org <= RST_ORIGIN;
            r_ceil_org  <= RST_ORIGIN;
            r_dir_x     <= RST_VIEW_DIR_X;
            r_dir_y     <= RST_VIEW_DIR_Y;
            r_plane_x   <= RST_CAM_PLANE_X;
            r_plane_y   <= RST_CAM_PLANE_Y;
            r_hdiv      <= RST_HORIZON_DIV;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_FLOOR_ORIGIN: r_floor_org <= i_cfg.data;
                CFG_CEIL_ORIGIN:  r_ceil_org  <= i_cfg.data;
                CFG_VIEW_DIR_X:   r_dir_x     <= i_cfg.data[VEC_W-1:0];
                CFG_VIEW_DIR_Y:   r_dir_y     <= i_cfg.data[VEC_W-1:0];
                CFG_CAM_PLANE_X:  r_plane_x   <= i_cfg.data[VEC_W-1:0];
                CFG_CAM_PLANE_Y:  r_plane_y   <= i_cfg.data[VEC_W-1:0];
                CFG_HORIZON_DIV:  r_hdiv      <= i_cfg.data[HDIV_W-1:0];
                default: ;
            endcase
        end
    end

    // horizon row table, zero divisor acts as one
    logic [HB-1:0]     w_hz_tab [0:31];
    logic [HB-1:0]     w_hz;
    logic [HDIV_W-1:0] w_div_eff;

    for (genvar g = 0; g < 32; g++) begin : g_hz
        localparam int HZ = SCREEN_HEIGHT / ((g == 0) ? 1 : g);
        assign w_hz_tab[g] = HB'(HZ);
    end

    assign w_hz      = w_hz_tab[r_hdiv];
    assign w_div_eff = (r_hdiv == '0) ? HDIV_W'(1) : r_hdiv;

    // global advance: the pipeline moves unless the result register is held
    logic r_out_valid;
    logic w_adv;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = w_adv;

    // entry stage
    t_info r_a;
    t_info n_a;

    always_comb begin
        n_a.valid      = i_in.valid;
        n_a.command    = i_in.command;
        n_a.keep       = 1'b0;
        n_a.surface    = SURF_FLOOR;
        n_a.pixel_x    = i_in.pixel_x;
        n_a.pixel_y    = i_in.pixel_y;
        n_a.texel_addr = i_in.texel_addr;
        n_a.texel_data = i_in.texel_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else if (w_adv) begin
            r_a <= n_a;
        end
    end

    // classify the row and set up the distance division
    logic [CW-1:0]  w_py;
    logic [CW-1:0]  w_hz_e;
    logic           w_is_floor;
    logic           w_is_ceil;
    logic           w_px_ok;
    logic [CW-1:0]  w_ceil_den;
    t_info          n_b;
    logic [DNW-1:0] n_b_num;
    logic [DDW-1:0] n_b_den;
    logic           n_b_sat;

    always_comb begin
        w_py       = CW'(r_a.pixel_y);
        w_hz_e     = CW'(w_hz);
        w_is_floor = (w_py >= w_hz_e + CW'(1)) && (w_py + CW'(2) <= CW'(SCREEN_HEIGHT));
        w_is_ceil  = (w_py + CW'(2) <= w_hz_e);
        w_px_ok    = (CW'(r_a.pixel_x) + CW'(1)) < CW'(SCREEN_WIDTH);
        w_ceil_den = CW'(r_a.pixel_y) * CW'(w_div_eff);
        n_b        = r_a;
        n_b.keep   = (r_a.command == CMD_SHADE) && w_px_ok && (w_is_floor || w_is_ceil);
        n_b.surface = w_is_floor ? SURF_FLOOR : SURF_CEIL;
        n_b_num    = w_is_floor ? FLOOR_NUM : {w_hz, 16'b0};
        n_b_den    = w_is_floor ? DDW'(w_py - w_hz_e) : DDW'(w_ceil_den);
        n_b_sat    = !w_is_floor && (r_a.pixel_y == '0);
    end

    // distance divider, one quotient bit per stage
    t_info          r_dinfo [0:DNW];
    logic [DNW-1:0] r_dn    [0:DNW];
    logic [DDW-1:0] r_drem  [0:DNW];
    logic [DDW-1:0] r_dden  [0:DNW];
    logic           r_dsat  [0:DNW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dinfo[0].valid <= 1'b0;
        end else if (w_adv) begin
            r_dinfo[0] <= n_b;
            r_dn[0]    <= n_b_num;
            r_drem[0]  <= '0;
            r_dden[0]  <= n_b_den;
            r_dsat[0]  <= n_b_sat;
        end
    end

    for (genvar k = 1; k <= DNW; k++) begin : g_ddiv
        logic [DDW:0] w_t;
        logic         w_ge;
        logic [DDW:0] w_r;

        always_comb begin
            w_t  = {r_drem[k-1], r_dn[k-1][DNW-1]};
            w_ge = w_t >= {1'b0, r_dden[k-1]};
            w_r  = w_ge ? (w_t - {1'b0, r_dden[k-1]}) : w_t;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dinfo[k].valid <= 1'b0;
            end else if (w_adv) begin
                r_dinfo[k] <= r_dinfo[k-1];
                r_dn[k]    <= {r_dn[k-1][DNW-2:0], w_ge};
                r_drem[k]  <= w_r[DDW-1:0];
                r_dden[k]  <= r_dden[k-1];
                r_dsat[k]  <= r_dsat[k-1];
            end
        end
    end

    // clamp the distance and form the ray numerators
    logic [31:0]        w_dq;
    logic [DIST_W-1:0]  w_dist;
    logic signed [16:0] w_dmp_x;
    logic signed [16:0] w_dmp_y;
    logic signed [31:0] w_px2;
    logic signed [31:0] w_numx;
    logic signed [31:0] w_numy;

    always_comb begin
        w_dq    = 32'(r_dn[DNW]);
        w_dist  = (r_dsat[DNW] || (w_dq > 32'(DIST_MAX))) ? DIST_MAX : w_dq[DIST_W-1:0];
        w_dmp_x = 17'(r_dir_x) - 17'(r_plane_x);
        w_dmp_y = 17'(r_dir_y) - 17'(r_plane_y);
        w_px2   = $signed(32'({r_dinfo[DNW].pixel_x, 1'b0}));
        w_numx  = 32'(w_dmp_x) * 32'(SCREEN_WIDTH) + 32'(r_plane_x) * w_px2;
        w_numy  = 32'(w_dmp_y) * 32'(SCREEN_WIDTH) + 32'(r_plane_y) * w_px2;
    end

    t_info              r_cinfo;
    logic [DIST_W-1:0]  r_cd;
    logic signed [31:0] r_cnx;
    logic signed [31:0] r_cny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cinfo.valid <= 1'b0;
        end else if (w_adv) begin
            r_cinfo <= r_dinfo[DNW];
            r_cd    <= w_dist;
            r_cnx   <= w_numx;
            r_cny   <= w_numy;
        end
    end

    // partial products of distance times numerator
    t_info              r_einfo;
    logic [39:0]        r_elo_x;
    logic [39:0]        r_elo_y;
    logic signed [40:0] r_ehi_x;
    logic signed [40:0] r_ehi_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_einfo.valid <= 1'b0;
        end else if (w_adv) begin
            r_einfo <= r_cinfo;
            r_elo_x <= 40'(r_cd) * 40'(r_cnx[15:0]);
            r_elo_y <= 40'(r_cd) * 40'(r_cny[15:0]);
            r_ehi_x <= $signed({1'b0, r_cd}) * $signed(r_cnx[31:16]);
            r_ehi_y <= $signed({1'b0, r_cd}) * $signed(r_cny[31:16]);
        end
    end

    // sum, floor shift by 2^14, fold the sign for the width division
    logic signed [56:0] w_prod_x;
    logic signed [56:0] w_prod_y;
    logic               w_neg_x;
    logic               w_neg_y;
    logic [MW-1:0]      w_m_x;
    logic [MW-1:0]      w_m_y;

    always_comb begin
        w_prod_x = (57'(r_ehi_x) <<< 16) + $signed(57'(r_elo_x));
        w_prod_y = (57'(r_ehi_y) <<< 16) + $signed(57'(r_elo_y));
        w_neg_x  = w_prod_x[56];
        w_neg_y  = w_prod_y[56];
        w_m_x    = w_neg_x ? ~w_prod_x[55:14] : w_prod_x[55:14];
        w_m_y    = w_neg_y ? ~w_prod_y[55:14] : w_prod_y[55:14];
    end

    // folded dividends ahead of the reciprocal multiply
    t_info         r_minfo;
    logic [MW-1:0] r_mx;
    logic [MW-1:0] r_my;
    logic          r_mnegx;
    logic          r_mnegy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minfo.valid <= 1'b0;
        end else if (w_adv) begin
            r_minfo <= r_einfo;
            r_mx    <= w_m_x;
            r_my    <= w_m_y;
            r_mnegx <= w_neg_x;
            r_mnegy <= w_neg_y;
        end
    end

    // partial products of dividend and reciprocal halves
    t_info          r_pinfo;
    logic [PPW-1:0] r_pxhh;
    logic [PPW-1:0] r_pxhl;
    logic [PPW-1:0] r_pxlh;
    logic [PPW-1:0] r_pxll;
    logic [PPW-1:0] r_pyhh;
    logic [PPW-1:0] r_pyhl;
    logic [PPW-1:0] r_pylh;
    logic [PPW-1:0] r_pyll;
    logic           r_pnegx;
    logic           r_pnegy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pinfo.valid <= 1'b0;
        end else if (w_adv) begin
            r_pinfo <= r_minfo;
            r_pxhh  <= PPW'(r_mx[MW-1:NLW]) * PPW'(RECIP_HI);
            r_pxhl  <= PPW'(r_mx[MW-1:NLW]) * PPW'(RECIP_LO);
            r_pxlh  <= PPW'(r_mx[NLW-1:0]) * PPW'(RECIP_HI);
            r_pxll  <= PPW'(r_mx[NLW-1:0]) * PPW'(RECIP_LO);
            r_pyhh  <= PPW'(r_my[MW-1:NLW]) * PPW'(RECIP_HI);
            r_pyhl  <= PPW'(r_my[MW-1:NLW]) * PPW'(RECIP_LO);
            r_pylh  <= PPW'(r_my[NLW-1:0]) * PPW'(RECIP_HI);
            r_pyll  <= PPW'(r_my[NLW-1:0]) * PPW'(RECIP_LO);
            r_pnegx <= r_mnegx;
            r_pnegy <= r_mnegy;
        end
    end

    // two partial sums of the aligned products
    t_info         r_qinfo;
    logic [PW-1:0] r_qxa;
    logic [PW-1:0] r_qxb;
    logic [PW-1:0] r_qya;
    logic [PW-1:0] r_qyb;
    logic          r_qnegx;
    logic          r_qnegy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qinfo.valid <= 1'b0;
        end else if (w_adv) begin
            r_qinfo <= r_pinfo;
            r_qxa   <= (PW'(r_pxhh) << (NLW + RLW)) + (PW'(r_pxhl) << NLW);
            r_qxb   <= (PW'(r_pxlh) << RLW) + PW'(r_pxll);
            r_qya   <= (PW'(r_pyhh) << (NLW + RLW)) + (PW'(r_pyhl) << NLW);
            r_qyb   <= (PW'(r_pylh) << RLW) + PW'(r_pyll);
            r_qnegx <= r_pnegx;
            r_qnegy <= r_pnegy;
        end
    end

    // final sum, the high bits are the quotient by the screen width
    logic [PW-1:0] w_sum_x;
    logic [PW-1:0] w_sum_y;

    always_comb begin
        w_sum_x = r_qxa + r_qxb;
        w_sum_y = r_qya + r_qyb;
    end

    t_info         r_rinfo;
    logic [MW-1:0] r_qx;
    logic [MW-1:0] r_qy;
    logic          r_rnegx;
    logic          r_rnegy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rinfo.valid <= 1'b0;
        end else if (w_adv) begin
            r_rinfo <= r_qinfo;
            r_qx    <= MW'(w_sum_x >> WS);
            r_qy    <= MW'(w_sum_y >> WS);
            r_rnegx <= r_qnegx;
            r_rnegy <= r_qnegy;
        end
    end

    // world coordinate, texel indexes and memory address
    logic [23:0]                w_org_x;
    logic [23:0]                w_org_y;
    logic signed [MW:0]         w_q_x;
    logic signed [MW:0]         w_q_y;
    logic signed [MW+1:0]       w_c_x;
    logic signed [MW+1:0]       w_c_y;
    logic [MW+1:0]              w_mag_x;
    logic [MW+1:0]              w_mag_y;
    logic [TEX_WIDTH_LOG2-1:0]  w_mt_x;
    logic [TEX_HEIGHT_LOG2-1:0] w_mt_y;
    logic [TEX_WIDTH_LOG2-1:0]  w_tx;
    logic [TEX_HEIGHT_LOG2-1:0] w_ty;
    logic [TEX_WIDTH_LOG2+TEX_HEIGHT_LOG2+ADDR_W-1:0] w_addr_ext;
    logic [ADDR_W-1:0]          w_addr;

    always_comb begin
        w_org_x = (r_rinfo.surface == SURF_CEIL) ? r_ceil_org[47:24] : r_floor_org[47:24];
        w_org_y = (r_rinfo.surface == SURF_CEIL) ? r_ceil_org[23:0]  : r_floor_org[23:0];
        w_q_x   = r_rnegx ? $signed(~{1'b0, r_qx}) : $signed({1'b0, r_qx});
        w_q_y   = r_rnegy ? $signed(~{1'b0, r_qy}) : $signed({1'b0, r_qy});
        w_c_x   = (MW+2)'($signed(w_org_x)) + (MW+2)'(w_q_x);
        w_c_y   = (MW+2)'($signed(w_org_y)) + (MW+2)'(w_q_y);
        w_mag_x = w_c_x[MW+1] ? (MW+2)'(-w_c_x) : w_c_x;
        w_mag_y = w_c_y[MW+1] ? (MW+2)'(-w_c_y) : w_c_y;
        w_mt_x  = w_mag_x[15 -: TEX_WIDTH_LOG2];
        w_mt_y  = w_mag_y[15 -: TEX_HEIGHT_LOG2];
        w_tx    = w_c_x[MW+1] ? (TEX_WIDTH_LOG2'(0) - w_mt_x) : w_mt_x;
        w_ty    = w_c_y[MW+1] ? (TEX_HEIGHT_LOG2'(0) - w_mt_y) : w_mt_y;
        w_addr_ext = {{ADDR_W{1'b0}}, w_ty, w_tx};
        w_addr  = (r_rinfo.command == CMD_SHADE) ? w_addr_ext[ADDR_W-1:0]
                                                 : r_rinfo.texel_addr;
    end

    t_info             r_ginfo;
    logic [ADDR_W-1:0] r_gaddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ginfo.valid <= 1'b0;
        end else if (w_adv) begin
            r_ginfo <= r_rinfo;
            r_gaddr <= w_addr;
        end
    end

    // texture memory, one port: loads write, shades read
    logic [TEXEL_W-1:0] r_mem [0:(1 << ADDR_W)-1];
    logic [TEXEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_adv && r_ginfo.valid) begin
            if (r_ginfo.command == CMD_LOAD) begin
                r_mem[r_gaddr] <= r_ginfo.texel_data;
            end
            r_rdata <= r_mem[r_gaddr];
        end
    end

    // result register
    logic [PIX_X_W-1:0] r_out_x;
    logic [PIX_Y_W-1:0] r_out_y;
    logic               r_out_surf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_ginfo.valid && r_ginfo.keep;
            r_out_x     <= r_ginfo.pixel_x;
            r_out_y     <= r_ginfo.pixel_y;
            r_out_surf  <= r_ginfo.surface;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.out_x   = r_out_x;
    assign o_out.out_y   = r_out_y;
    assign o_out.color   = r_rdata;
    assign o_out.surface = r_out_surf;

endmodule

@@ dv/tb.sv @@
// tb: self-checking bench for floor_ceiling_texel_caster, directed table then random traffic
// depends on fctc_pkg, the fctc channel interfaces and the top level rtl

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fctc_pkg::*;

    localparam int SW = DEF_SCREEN_WIDTH;
    localparam int SH = DEF_SCREEN_HEIGHT;
    localparam int TWL = DEF_TEX_WIDTH_LOG2;
    localparam int THL = DEF_TEX_HEIGHT_LOG2;
    localparam int LATENCY = 35;

    typedef enum int {WANT_NONE, WANT_FLOOR, WANT_CEIL, WANT_PRED} t_want;

    typedef struct {
        logic                cmd;
        logic [PIX_X_W-1:0]  px;
        logic [PIX_Y_W-1:0]  py;
        logic [ADDR_W-1:0]   addr;
        logic [TEXEL_W-1:0]  data;
        t_want               want;
    } t_row;

    typedef struct {
        logic [PIX_X_W-1:0]  x;
        logic [PIX_Y_W-1:0]  y;
        logic [TEXEL_W-1:0]  color;
        logic                surf;
    } t_pixel;

    logic i_clk;
    logic i_rst_n;

    fctc_in_if  in_ch();
    fctc_out_if out_ch();
    fctc_cfg_if cfg_ch();

    floor_ceiling_texel_caster dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // shadow of the block state
    logic [TEXEL_W-1:0]  texels [4096];
    bit                  texel_written [4096];
    logic [ORIGIN_W-1:0] floor_org, ceil_org;
    logic [VEC_W-1:0]    dir_x, dir_y, plane_x, plane_y;
    logic [HDIV_W-1:0]   hdiv;

    t_pixel pending_pixels[$];
    int     errors;
    int     src_idle, snk_idle;
    int     hold_cycles;

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // world coordinate on one axis, Q.16
    function automatic longint world_coord(longint org, longint row_dist, longint dir,
                                           longint plane, longint x);
        longint numer, prod, den;
        numer = (dir - plane) * SW + 2 * plane * x;
        prod  = row_dist * numer;
        den   = longint'(SW) * 16384;
        if (prod >= 0)
            return org + prod / den;
        return org - ((-prod + den - 1) / den);
    endfunction

    // texel index from the coordinate fraction
    function automatic int tex_coord(longint c, int lg);
        longint mag, m, mask;
        mag  = (c < 0) ? -c : c;
        mask = (longint'(1) << lg) - 1;
        m    = ((mag & 64'hFFFF) << lg) >> 16;
        if (c < 0)
            return int'((-m) & mask);
        return int'(m & mask);
    endfunction

    // surface and texel address of one pixel; 0 when no result
    function automatic bit cast_pixel(input logic [PIX_X_W-1:0] x, input logic [PIX_Y_W-1:0] y,
                                      output logic surf, output logic [ADDR_W-1:0] addr);
        longint div, hz, row_dist, cx, cy, ox, oy;
        logic [ORIGIN_W-1:0] org;
        int tx, ty;
        div = (hdiv == 0) ? 1 : hdiv;
        hz  = SH / div;
        surf = SURF_FLOOR;
        addr = '0;
        if (x + 1 >= SW)
            return 0;
        if (y >= hz + 1 && y + 2 <= SH) begin
            surf = SURF_FLOOR;
            org  = floor_org;
            row_dist = (longint'(SH) << 15) / (y - hz);
        end else if (y + 2 <= hz) begin
            surf = SURF_CEIL;
            org  = ceil_org;
            row_dist = (y == 0) ? longint'(DIST_MAX) : ((hz << 16) / (y * div));
        end else begin
            return 0;
        end
        if (row_dist > longint'(DIST_MAX))
            row_dist = DIST_MAX;
        ox = $signed(org[47:24]);
        oy = $signed(org[23:0]);
        cx = world_coord(ox, row_dist, longint'($signed(dir_x)), longint'($signed(plane_x)), x);
        cy = world_coord(oy, row_dist, longint'($signed(dir_y)), longint'($signed(plane_y)), x);
        tx = tex_coord(cx, TWL);
        ty = tex_coord(cy, THL);
        addr = ADDR_W'((ty << TWL) + tx);
        return 1;
    endfunction

    // register write, only while idle
    task automatic write_reg(t_cfg_idx idx, logic [ORIGIN_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_FLOOR_ORIGIN: floor_org = value;
            CFG_CEIL_ORIGIN:  ceil_org  = value;
            CFG_VIEW_DIR_X:   dir_x     = value[VEC_W-1:0];
            CFG_VIEW_DIR_Y:   dir_y     = value[VEC_W-1:0];
            CFG_CAM_PLANE_X:  plane_x   = value[VEC_W-1:0];
            CFG_CAM_PLANE_Y:  plane_y   = value[VEC_W-1:0];
            CFG_HORIZON_DIV:  hdiv      = value[HDIV_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // one command transfer; the shadow is updated at the accepting edge
    task automatic drive_cmd(logic cmd, logic [PIX_X_W-1:0] x, logic [PIX_Y_W-1:0] y,
                             logic [ADDR_W-1:0] addr, logic [TEXEL_W-1:0] data);
        logic surf;
        logic [ADDR_W-1:0] taddr;
        t_pixel p;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.pixel_x    <= x;
        in_ch.pixel_y    <= y;
        in_ch.texel_addr <= addr;
        in_ch.texel_data <= data;
        do @(posedge i_clk); while (!in_ch.ready);
        if (cmd == CMD_LOAD) begin
            texels[addr] = data;
            texel_written[addr] = 1'b1;
        end else if (cast_pixel(x, y, surf, taddr)) begin
            p.x = x;
            p.y = y;
            p.color = texels[taddr];
            p.surf = surf;
            pending_pixels.push_back(p);
        end
    endtask

    // issue a command; a shade that would hit a blank texel gets a load first
    task automatic issue(t_row r);
        logic surf;
        logic [ADDR_W-1:0] taddr;
        bit hit;
        hit = 1'b0;
        if (r.cmd == CMD_SHADE) begin
            hit = cast_pixel(r.px, r.py, surf, taddr);
            if (hit && !texel_written[taddr])
                drive_cmd(CMD_LOAD, '0, '0, taddr, $urandom);
        end
        if ((r.want == WANT_NONE && hit) ||
            (r.want == WANT_FLOOR && !(hit && surf == SURF_FLOOR)) ||
            (r.want == WANT_CEIL && !(hit && surf == SURF_CEIL))) begin
            $display("%0t: row x=%0d y=%0d expected outcome %s, predictor hit=%0b surf=%0b",
                     $time, r.px, r.py, r.want.name(), hit, surf);
            errors++;
        end
        drive_cmd(r.cmd, r.px, r.py, r.addr, r.data);
    endtask

    // wait for every expected pixel, then for in-flight loads
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic random_burst(int count);
        t_row r;
        for (int k = 0; k < count; k++) begin
            r.want = WANT_PRED;
            r.cmd  = ($urandom_range(99) < 15) ? CMD_LOAD : CMD_SHADE;
            r.addr = $urandom;
            r.data = $urandom;
            if ($urandom_range(99) < 8) begin
                r.px = $urandom;
                r.py = $urandom;
            end else begin
                r.px = $urandom_range(SW - 1);
                r.py = $urandom_range(SH - 1);
            end
            issue(r);
            if (k == count / 3 && hold_cycles == 0 && $urandom_range(3) == 0)
                hold_cycles = 400;
        end
    endtask

    // receiver ready, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    // result check against the oldest expected pixel
    always @(posedge i_clk) begin
        t_pixel e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel x=%0d y=%0d color=%h surf=%0b", $time,
                         out_ch.out_x, out_ch.out_y, out_ch.color, out_ch.surface);
                errors++;
            end else begin
                e = pending_pixels.pop_front();
                if (out_ch.out_x !== e.x || out_ch.out_y !== e.y ||
                    out_ch.color !== e.color || out_ch.surface !== e.surf) begin
                    $display("%0t: pixel mismatch expected x=%0d y=%0d color=%h surf=%0b",
                             $time, e.x, e.y, e.color, e.surf);
                    $display("%0t:                actual   x=%0d y=%0d color=%h surf=%0b",
                             $time, out_ch.out_x, out_ch.out_y, out_ch.color,
                             out_ch.surface);
                    errors++;
                end
            end
        end
    end

    // overall time limit
    initial begin
        #8ms;
        $display("tb failed");
        $finish;
    end

    // directed table at reset settings: horizon row 240
    t_row dir_rows[] = '{
        '{CMD_LOAD,  10'd0,    9'd0,   12'd4095, 32'hFFFFFFFF, WANT_NONE},
        '{CMD_LOAD,  10'd1023, 9'd511, 12'd0,    32'h00000000, WANT_NONE},
        '{CMD_SHADE, 10'd0,    9'd0,   12'd0,    32'd0,        WANT_CEIL},
        '{CMD_SHADE, 10'd320,  9'd0,   12'd0,    32'd0,        WANT_CEIL},
        '{CMD_SHADE, 10'd638,  9'd1,   12'd0,    32'd0,        WANT_CEIL},
        '{CMD_SHADE, 10'd100,  9'd238, 12'd0,    32'd0,        WANT_CEIL},
        '{CMD_SHADE, 10'd100,  9'd239, 12'd0,    32'd0,        WANT_NONE},
        '{CMD_SHADE, 10'd100,  9'd240, 12'd0,    32'd0,        WANT_NONE},
        '{CMD_SHADE, 10'd0,    9'd241, 12'd0,    32'd0,        WANT_FLOOR},
        '{CMD_SHADE, 10'd638,  9'd478, 12'd0,    32'd0,        WANT_FLOOR},
        '{CMD_SHADE, 10'd5,    9'd479, 12'd0,    32'd0,        WANT_NONE},
        '{CMD_SHADE, 10'd639,  9'd300, 12'd0,    32'd0,        WANT_NONE},
        '{CMD_SHADE, 10'd1023, 9'd300, 12'd0,    32'd0,        WANT_NONE},
        '{CMD_SHADE, 10'd200,  9'd511, 12'd0,    32'd0,        WANT_NONE},
        '{CMD_SHADE, 10'd511,  9'd255, 12'd0,    32'd0,        WANT_PRED},
        '{CMD_SHADE, 10'd300,  9'd100, 12'd0,    32'd0,        WANT_PRED}
    };

    initial begin
        errors = 0;
        src_idle = 0;
        snk_idle = 0;
        hold_cycles = 0;
        floor_org = RST_ORIGIN;
        ceil_org  = RST_ORIGIN;
        dir_x = RST_VIEW_DIR_X;
        dir_y = RST_VIEW_DIR_Y;
        plane_x = RST_CAM_PLANE_X;
        plane_y = RST_CAM_PLANE_Y;
        hdiv = RST_HORIZON_DIV;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_LOAD;
        in_ch.pixel_x = '0;
        in_ch.pixel_y = '0;
        in_ch.texel_addr = '0;
        in_ch.texel_data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_FLOOR_ORIGIN;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset settings
        foreach (dir_rows[i])
            issue(dir_rows[i]);
        drain();

        // settings sweep with random traffic per phase
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 3) begin
                src_idle = 15;
                snk_idle = 68;
            end else if (ph < 6) begin
                src_idle = 68;
                snk_idle = 15;
            end else begin
                src_idle = 0;
                snk_idle = 0;
            end
            case (ph)
                0: begin
                    write_reg(CFG_HORIZON_DIV, 48'd1);
                    write_reg(CFG_VIEW_DIR_X, 48'h7FFF);
                    write_reg(CFG_CAM_PLANE_Y, 48'h8000);
                end
                1: begin
                    write_reg(CFG_HORIZON_DIV, 48'd16);
                    write_reg(CFG_FLOOR_ORIGIN, 48'hFFFF_FFFF_FFFF);
                    write_reg(CFG_CEIL_ORIGIN, 48'h8000_0080_0000);
                    write_reg(CFG_VIEW_DIR_Y, 48'h8000);
                end
                2: begin
                    write_reg(CFG_HORIZON_DIV, 48'd0);
                    write_reg(CFG_CAM_PLANE_X, 48'h7FFF);
                    write_reg(CFG_VIEW_DIR_X, 48'h8000);
                end
                3: begin
                    write_reg(CFG_HORIZON_DIV, 48'd31);
                    write_reg(CFG_CEIL_ORIGIN, 48'h7FFF_FF7F_FFFF);
                    write_reg(CFG_CAM_PLANE_X, 48'h8000);
                end
                default: begin
                    write_reg(CFG_HORIZON_DIV, 48'($urandom_range(1, 16)));
                    write_reg(CFG_FLOOR_ORIGIN, {$urandom, $urandom});
                    write_reg(CFG_CEIL_ORIGIN, {$urandom, $urandom});
                    write_reg(CFG_VIEW_DIR_X, 48'($urandom));
                    write_reg(CFG_VIEW_DIR_Y, 48'($urandom));
                    write_reg(CFG_CAM_PLANE_X, 48'($urandom));
                    write_reg(CFG_CAM_PLANE_Y, 48'($urandom));
                end
            endcase
            if (ph == 1)
                hold_cycles = 500;
            random_burst(28);
            if (ph == 4) begin
                // sender waits for every expected pixel to come back
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                while (pending_pixels.size() != 0)
                    @(posedge i_clk);
            end
            random_burst(28);
            drain();
        end

        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
